// ===== hdl/erct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package erct_pkg;

    // fixed field widths
    localparam int RW  = 28;          // radius and line width
    localparam int MW  = 30;          // doubled length operand of the ellipse test
    localparam int HW  = MW;          // half of a squared operand
    localparam int SQW = 2 * MW;      // squared length
    localparam int WPW = 2 * SQW;     // product of two squares
    localparam int LW  = WPW + 2;     // sum of two such products
    localparam int NPROD = 6;

    // register indexes of the configuration port
    localparam int IDXW = 4;
    typedef logic [IDXW-1:0] t_reg_idx;
    localparam t_reg_idx REG_INV_XX   = 4'd0;
    localparam t_reg_idx REG_INV_XY   = 4'd1;
    localparam t_reg_idx REG_INV_XT   = 4'd2;
    localparam t_reg_idx REG_INV_YX   = 4'd3;
    localparam t_reg_idx REG_INV_YY   = 4'd4;
    localparam t_reg_idx REG_INV_YT   = 4'd5;
    localparam t_reg_idx REG_RADIUS_X = 4'd6;
    localparam t_reg_idx REG_RADIUS_Y = 4'd7;

    // control that travels with each word through the pipeline
    typedef struct packed {
        logic vld;    // stage holds a word
        logic kill;   // a radius is zero
        logic fillc;  // inner ellipse test is waived (fill or thick stroke)
    } t_ctl;

    typedef logic [SQW-1:0] t_sq;

endpackage
`default_nettype wire

// ===== hdl/erct_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface erct_pix_if #(parameter int CW = 12);
    logic                     valid;
    logic                     ready;
    logic signed [CW-1:0]     pixel_x;
    logic signed [CW-1:0]     pixel_y;
    logic [erct_pkg::RW-1:0]  line_width;
    logic                     fill_mode;
    modport source (output valid, pixel_x, pixel_y, line_width, fill_mode, input ready);
    modport sink   (input valid, pixel_x, pixel_y, line_width, fill_mode, output ready);
endinterface

interface erct_cov_if #(parameter int CW = 12);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] out_x;
    logic signed [CW-1:0] out_y;
    logic                 covered;
    modport source (output valid, out_x, out_y, covered, input ready);
    modport sink   (input valid, out_x, out_y, covered, output ready);
endinterface

interface erct_cfg_if;
    logic                  valid;
    logic                  ready;
    erct_pkg::t_reg_idx    index;
    logic [31:0]           data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/ellipse_ring_coverage_test.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pixel coverage test for an affine-mapped ellipse or elliptical ring. Load the
// inverse matrix rows and the radii through the configuration channel while the
// pipeline is empty; then stream one pixel word per clock with its stroke width
// and fill flag. Each word returns one result word (pixel echo plus covered
// flag), in order. The pipeline takes a new word in every cycle and only holds
// when the output register is full and not taken; the depth is set by the chain
// matrix product, centring, magnitude, squaring, split 60 by 60 products,
// product assembly and the final compare.
module ellipse_ring_coverage_test #(
    parameter int FRAC_BITS  = 16,
    parameter int COORD_BITS = 12
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    erct_pix_if.sink    i_pix,
    erct_cfg_if.sink    i_cfg,
    erct_cov_if.source  o_cov
);
    localparam int CW = COORD_BITS;
    localparam int RW = erct_pkg::RW;
    localparam int MW = erct_pkg::MW;
    localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

    // configuration registers
    logic signed [31:0] r_xx, r_xy, r_xt, r_yx, r_yy, r_yt;
    logic [RW-1:0]      r_rx, r_ry;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xx <= ONE;
            r_xy <= '0;
            r_xt <= '0;
            r_yx <= '0;
            r_yy <= ONE;
            r_yt <= '0;
            r_rx <= '0;
            r_ry <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                erct_pkg::REG_INV_XX:   r_xx <= i_cfg.data;
                erct_pkg::REG_INV_XY:   r_xy <= i_cfg.data;
                erct_pkg::REG_INV_XT:   r_xt <= i_cfg.data;
                erct_pkg::REG_INV_YX:   r_yx <= i_cfg.data;
                erct_pkg::REG_INV_YY:   r_yy <= i_cfg.data;
                erct_pkg::REG_INV_YT:   r_yt <= i_cfg.data;
                erct_pkg::REG_RADIUS_X: r_rx <= i_cfg.data[RW-1:0];
                erct_pkg::REG_RADIUS_Y: r_ry <= i_cfg.data[RW-1:0];
                default: ;
            endcase
        end
    end

    // advance the whole pipeline unless the output word is stuck
    logic w_en;
    assign w_en        = !o_cov.valid || o_cov.ready;
    assign i_pix.ready = w_en;

    erct_pkg::t_ctl       w_ctl;
    logic signed [CW-1:0] w_x, w_y;
    logic [CW+34:0]       w_ax, w_ay;
    logic [MW-1:0]        w_ox, w_oy, w_ix, w_iy;

    erct_xform #(.CW(CW)) u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (i_pix.valid),
        .i_x     (i_pix.pixel_x),
        .i_y     (i_pix.pixel_y),
        .i_lw    (i_pix.line_width),
        .i_fill  (i_pix.fill_mode),
        .i_xx    (r_xx),
        .i_xy    (r_xy),
        .i_xt    (r_xt),
        .i_yx    (r_yx),
        .i_yy    (r_yy),
        .i_yt    (r_yt),
        .i_rx    (r_rx),
        .i_ry    (r_ry),
        .o_ctl   (w_ctl),
        .o_x     (w_x),
        .o_y     (w_y),
        .o_ax    (w_ax),
        .o_ay    (w_ay),
        .o_ox    (w_ox),
        .o_oy    (w_oy),
        .o_ix    (w_ix),
        .o_iy    (w_iy)
    );

    erct_ellip #(.CW(CW)) u_ellip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_ctl),
        .i_x     (w_x),
        .i_y     (w_y),
        .i_ax    (w_ax),
        .i_ay    (w_ay),
        .i_ox    (w_ox),
        .i_oy    (w_oy),
        .i_ix    (w_ix),
        .i_iy    (w_iy),
        .o_vld   (o_cov.valid),
        .o_x     (o_cov.out_x),
        .o_y     (o_cov.out_y),
        .o_cov   (o_cov.covered)
    );

`ifndef ASSERT_OFF
    // input side follows the output stall exactly
    a_ready_follows_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.ready == (!o_cov.valid || o_cov.ready))
        else $error("input ready does not track output stall");

    // reset empties the pipeline
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_cov.valid)
        else $error("output valid after reset");

    // a stalled pipeline keeps the valid flag at the output of the transform stages
    a_stall_holds_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_ctl.vld))
        else $error("pipeline moved while stalled");
`endif

endmodule
`default_nettype wire

// ===== hdl/erct_xform.sv =====
`timescale 1ns / 1ps
`default_nettype none
module erct_xform #(
    parameter int CW = 12
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire logic                      i_vld,
    input  wire logic signed [CW-1:0]      i_x,
    input  wire logic signed [CW-1:0]      i_y,
    input  wire logic [erct_pkg::RW-1:0]   i_lw,
    input  wire logic                      i_fill,
    input  wire logic signed [31:0]        i_xx,
    input  wire logic signed [31:0]        i_xy,
    input  wire logic signed [31:0]        i_xt,
    input  wire logic signed [31:0]        i_yx,
    input  wire logic signed [31:0]        i_yy,
    input  wire logic signed [31:0]        i_yt,
    input  wire logic [erct_pkg::RW-1:0]   i_rx,
    input  wire logic [erct_pkg::RW-1:0]   i_ry,
    output erct_pkg::t_ctl                 o_ctl,
    output logic signed [CW-1:0]           o_x,
    output logic signed [CW-1:0]           o_y,
    output logic [CW+34:0]                 o_ax,
    output logic [CW+34:0]                 o_ay,
    output logic [erct_pkg::MW-1:0]        o_ox,
    output logic [erct_pkg::MW-1:0]        o_oy,
    output logic [erct_pkg::MW-1:0]        o_ix,
    output logic [erct_pkg::MW-1:0]        o_iy
);
    localparam int PW = CW + 32;   // one matrix product
    localparam int SW = PW + 2;    // row sum less the radius
    localparam int DW = SW + 1;    // doubled centred coordinate
    localparam int MW = erct_pkg::MW;
    localparam int RW = erct_pkg::RW;

    // stage A: matrix products
    logic                 r_a_vld;
    logic signed [PW-1:0] r_a_pxx, r_a_pxy, r_a_pyx, r_a_pyy;
    logic signed [CW-1:0] r_a_x, r_a_y;
    logic [RW-1:0]        r_a_lw;
    logic                 r_a_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_pxx  <= PW'(i_xx) * PW'(i_x);
            r_a_pxy  <= PW'(i_xy) * PW'(i_y);
            r_a_pyx  <= PW'(i_yx) * PW'(i_x);
            r_a_pyy  <= PW'(i_yy) * PW'(i_y);
            r_a_x    <= i_x;
            r_a_y    <= i_y;
            r_a_lw   <= i_lw;
            r_a_fill <= i_fill;
        end
    end

    // stage B: row sums, centring, radii of both ellipses
    logic signed [32:0]   n_tx, n_ty;
    logic signed [SW-1:0] n_u, n_v;
    logic [MW-1:0]        n_rx2, n_ry2, n_lw;

    assign n_tx  = 33'(i_xt) - 33'($signed({1'b0, i_rx}));
    assign n_ty  = 33'(i_yt) - 33'($signed({1'b0, i_ry}));
    assign n_u   = SW'(r_a_pxx) + SW'(r_a_pxy) + SW'(n_tx);
    assign n_v   = SW'(r_a_pyx) + SW'(r_a_pyy) + SW'(n_ty);
    assign n_rx2 = MW'({i_rx, 1'b0});
    assign n_ry2 = MW'({i_ry, 1'b0});
    assign n_lw  = MW'(r_a_lw);

    logic                 r_b_vld;
    logic signed [DW-1:0] r_b_dx, r_b_dy;
    logic [MW-1:0]        r_b_ox, r_b_oy, r_b_ix, r_b_iy;
    logic                 r_b_kill, r_b_fillc;
    logic signed [CW-1:0] r_b_x, r_b_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_dx    <= {n_u, 1'b0};
            r_b_dy    <= {n_v, 1'b0};
            r_b_ox    <= n_rx2 + n_lw;
            r_b_oy    <= n_ry2 + n_lw;
            r_b_ix    <= n_rx2 - n_lw;
            r_b_iy    <= n_ry2 - n_lw;
            r_b_kill  <= (i_rx == '0) || (i_ry == '0);
            r_b_fillc <= r_a_fill || (n_lw >= n_rx2) || (n_lw >= n_ry2);
            r_b_x     <= r_a_x;
            r_b_y     <= r_a_y;
        end
    end

    // stage C: magnitudes
    logic [DW-1:0] n_ax, n_ay;

    assign n_ax = r_b_dx[DW-1] ? DW'(-r_b_dx) : DW'(r_b_dx);
    assign n_ay = r_b_dy[DW-1] ? DW'(-r_b_dy) : DW'(r_b_dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctl.vld <= 1'b0;
        end else if (i_en) begin
            o_ctl.vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctl.kill  <= r_b_kill;
            o_ctl.fillc <= r_b_fillc;
            o_ax        <= n_ax;
            o_ay        <= n_ay;
            o_ox        <= r_b_ox;
            o_oy        <= r_b_oy;
            o_ix        <= r_b_ix;
            o_iy        <= r_b_iy;
            o_x         <= r_b_x;
            o_y         <= r_b_y;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/erct_ellip.sv =====
`timescale 1ns / 1ps
`default_nettype none
module erct_ellip #(
    parameter int CW = 12
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_en,
    input  wire erct_pkg::t_ctl            i_ctl,
    input  wire logic signed [CW-1:0]      i_x,
    input  wire logic signed [CW-1:0]      i_y,
    input  wire logic [CW+34:0]            i_ax,
    input  wire logic [CW+34:0]            i_ay,
    input  wire logic [erct_pkg::MW-1:0]   i_ox,
    input  wire logic [erct_pkg::MW-1:0]   i_oy,
    input  wire logic [erct_pkg::MW-1:0]   i_ix,
    input  wire logic [erct_pkg::MW-1:0]   i_iy,
    output logic                           o_vld,
    output logic signed [CW-1:0]           o_x,
    output logic signed [CW-1:0]           o_y,
    output logic                           o_cov
);
    localparam int DW  = CW + 35;
    localparam int MW  = erct_pkg::MW;
    localparam int HW  = erct_pkg::HW;
    localparam int SQW = erct_pkg::SQW;
    localparam int WPW = erct_pkg::WPW;
    localparam int LW  = erct_pkg::LW;
    localparam int NP  = erct_pkg::NPROD;

    // squares: 0 ax, 1 ay, 2 ox, 3 oy, 4 ix, 5 iy
    // products: ax*oy, ay*ox, ox*oy, ax*iy, ay*ix, ix*iy (all squared)
    localparam int SEL_A [NP] = '{0, 1, 2, 0, 1, 4};
    localparam int SEL_B [NP] = '{3, 2, 3, 5, 4, 5};

    // stage D: outer box check and squares
    logic [MW-1:0] w_op [NP];

    assign w_op[0] = i_ax[MW-1:0];
    assign w_op[1] = i_ay[MW-1:0];
    assign w_op[2] = i_ox;
    assign w_op[3] = i_oy;
    assign w_op[4] = i_ix;
    assign w_op[5] = i_iy;

    erct_pkg::t_ctl       r_d_ctl;
    logic                 r_d_far;
    erct_pkg::t_sq        r_d_sq [NP];
    logic signed [CW-1:0] r_d_x, r_d_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_ctl.vld <= 1'b0;
        end else if (i_en) begin
            r_d_ctl.vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_ctl.kill  <= i_ctl.kill;
            r_d_ctl.fillc <= i_ctl.fillc;
            r_d_far       <= (i_ax > DW'(i_ox)) || (i_ay > DW'(i_oy));
            for (int k = 0; k < NP; k++) begin
                r_d_sq[k] <= SQW'(w_op[k]) * SQW'(w_op[k]);
            end
            r_d_x <= i_x;
            r_d_y <= i_y;
        end
    end

    // stage E: partial products of the wide multiplications
    erct_pkg::t_ctl       r_e_ctl;
    logic                 r_e_far;
    erct_pkg::t_sq        r_e_hh [NP];
    erct_pkg::t_sq        r_e_hl [NP];
    erct_pkg::t_sq        r_e_lh [NP];
    erct_pkg::t_sq        r_e_ll [NP];
    logic signed [CW-1:0] r_e_x, r_e_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_ctl.vld <= 1'b0;
        end else if (i_en) begin
            r_e_ctl.vld <= r_d_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_ctl.kill  <= r_d_ctl.kill;
            r_e_ctl.fillc <= r_d_ctl.fillc;
            r_e_far       <= r_d_far;
            for (int k = 0; k < NP; k++) begin
                r_e_hh[k] <= SQW'(r_d_sq[SEL_A[k]][SQW-1:HW]) * SQW'(r_d_sq[SEL_B[k]][SQW-1:HW]);
                r_e_hl[k] <= SQW'(r_d_sq[SEL_A[k]][SQW-1:HW]) * SQW'(r_d_sq[SEL_B[k]][HW-1:0]);
                r_e_lh[k] <= SQW'(r_d_sq[SEL_A[k]][HW-1:0]) * SQW'(r_d_sq[SEL_B[k]][SQW-1:HW]);
                r_e_ll[k] <= SQW'(r_d_sq[SEL_A[k]][HW-1:0]) * SQW'(r_d_sq[SEL_B[k]][HW-1:0]);
            end
            r_e_x <= r_d_x;
            r_e_y <= r_d_y;
        end
    end

    // stage F: assemble the full products
    erct_pkg::t_ctl       r_f_ctl;
    logic                 r_f_far;
    logic [WPW-1:0]       r_f_p [NP];
    logic signed [CW-1:0] r_f_x, r_f_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_ctl.vld <= 1'b0;
        end else if (i_en) begin
            r_f_ctl.vld <= r_e_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_f_ctl.kill  <= r_e_ctl.kill;
            r_f_ctl.fillc <= r_e_ctl.fillc;
            r_f_far       <= r_e_far;
            for (int k = 0; k < NP; k++) begin
                r_f_p[k] <= {r_e_hh[k], r_e_ll[k]}
                          + (WPW'(r_e_hl[k]) << HW)
                          + (WPW'(r_e_lh[k]) << HW);
            end
            r_f_x <= r_e_x;
            r_f_y <= r_e_y;
        end
    end

    // stage G: compare against both ellipses, drive the output word
    logic [LW-1:0] n_lhs_o, n_lhs_i;
    logic          n_in_outer, n_out_inner;

    assign n_lhs_o     = LW'(r_f_p[0]) + LW'(r_f_p[1]);
    assign n_lhs_i     = LW'(r_f_p[3]) + LW'(r_f_p[4]);
    assign n_in_outer  = n_lhs_o <= LW'(r_f_p[2]);
    assign n_out_inner = n_lhs_i >= LW'(r_f_p[5]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= r_f_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cov <= !r_f_ctl.kill && !r_f_far && n_in_outer
                     && (r_f_ctl.fillc || n_out_inner);
            o_x   <= r_f_x;
            o_y   <= r_f_y;
        end
    end

endmodule
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;

    localparam int CW = 12;
    localparam int FB = 16;
    localparam int RW = erct_pkg::RW;
    localparam int NRAND = 2000;

    typedef struct packed {
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic [RW-1:0]        lw;
        logic                 fill;
    } t_pixel;

    typedef struct packed {
        logic signed [CW-1:0] ox;
        logic signed [CW-1:0] oy;
        logic                 cov;
    } t_coverage;

    logic i_clk;
    logic i_rst_n;

    erct_pix_if #(.CW(CW)) pix ();
    erct_cfg_if            cfg ();
    erct_cov_if #(.CW(CW)) cov ();

    ellipse_ring_coverage_test #(.FRAC_BITS(FB), .COORD_BITS(CW)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix.sink),
        .i_cfg   (cfg.sink),
        .o_cov   (cov.source)
    );

    // shadow copy of the register file
    logic signed [31:0] m_xx, m_xy, m_xt, m_yx, m_yy, m_yt;
    logic [RW-1:0]      rad_x, rad_y;

    t_pixel    pix_q[$];
    t_coverage cov_q[$];
    int        n_err;
    int        n_sent;
    int        n_seen;
    int        n_covered;
    int        send_idle;
    int        recv_stall;
    bit        hold_pix;
    bit        pix_acc;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // sign of a*ry^2 + b*rx^2 - rx^2*ry^2 with squares taken inside
    function automatic int side_of(logic [63:0] ax, logic [63:0] ay,
                                   logic [63:0] rx, logic [63:0] ry);
        logic [255:0] lhs;
        logic [255:0] rhs;
        lhs = 256'(ax * ax) * 256'(ry * ry) + 256'(ay * ay) * 256'(rx * rx);
        rhs = 256'(rx * rx) * 256'(ry * ry);
        if (lhs < rhs) return -1;
        if (lhs > rhs) return 1;
        return 0;
    endfunction

    // work out the covered flag of one pixel word
    function automatic t_coverage cover_pixel(t_pixel p);
        t_coverage r;
        logic signed [63:0] u, v, du, dv;
        logic [63:0] ax, ay, ox, oy, ix, iy;
        r.ox = p.px;
        r.oy = p.py;
        r.cov = 1'b0;
        if (rad_x != 0 && rad_y != 0) begin
            u = 64'(m_xx) * 64'(p.px) + 64'(m_xy) * 64'(p.py) + 64'(m_xt);
            v = 64'(m_yx) * 64'(p.px) + 64'(m_yy) * 64'(p.py) + 64'(m_yt);
            du = (u - $signed({36'd0, rad_x})) * 2;
            dv = (v - $signed({36'd0, rad_y})) * 2;
            ax = du < 0 ? -du : du;
            ay = dv < 0 ? -dv : dv;
            ox = 2 * 64'(rad_x) + 64'(p.lw);
            oy = 2 * 64'(rad_y) + 64'(p.lw);
            if (ax <= ox && ay <= oy && side_of(ax, ay, ox, oy) <= 0) begin
                if (p.fill || 64'(p.lw) >= 2 * 64'(rad_x) ||
                    64'(p.lw) >= 2 * 64'(rad_y)) begin
                    r.cov = 1'b1;
                end else begin
                    ix = 2 * 64'(rad_x) - 64'(p.lw);
                    iy = 2 * 64'(rad_y) - 64'(p.lw);
                    r.cov = side_of(ax, ay, ix, iy) >= 0;
                end
            end
        end
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        n_err++;
        $display("mismatch %0s: got %0d want %0d (word %0d)", what, got, want, n_seen);
    endtask

    // append one pending pixel word
    task automatic queue_pixel(t_pixel p);
        pix_q = {pix_q, p};
    endtask

    // driver: hand the next pending word over at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pix.valid <= 1'b0;
        end else if (pix.valid && !pix_acc) begin
            // hold until taken
        end else if (pix_q.size() > 0 && !hold_pix &&
                     $urandom_range(99) >= send_idle) begin
            pix.valid      <= 1'b1;
            pix.pixel_x    <= pix_q[0].px;
            pix.pixel_y    <= pix_q[0].py;
            pix.line_width <= pix_q[0].lw;
            pix.fill_mode  <= pix_q[0].fill;
            void'(pix_q.pop_front());
        end else begin
            pix.valid <= 1'b0;
        end
        cov.ready <= ($urandom_range(99) >= recv_stall);
    end

    // predict on acceptance, check each result word
    always @(posedge i_clk) begin
        t_coverage want;
        pix_acc = i_rst_n && pix.valid && pix.ready;
        if (pix_acc) begin
            cov_q = {cov_q, cover_pixel({pix.pixel_x, pix.pixel_y,
                                         pix.line_width, pix.fill_mode})};
            n_sent++;
        end
        if (i_rst_n && cov.valid && cov.ready) begin
            n_seen++;
            if (cov_q.size() == 0) begin
                report("unexpected word", 0, 0);
            end else begin
                want = cov_q.pop_front();
                if (cov.out_x !== want.ox) report("out_x", cov.out_x, want.ox);
                if (cov.out_y !== want.oy) report("out_y", cov.out_y, want.oy);
                if (cov.covered !== want.cov) report("covered", cov.covered, want.cov);
                n_covered += want.cov;
            end
        end
    end

    task automatic write_reg(erct_pkg::t_reg_idx idx, logic [31:0] val);
        @(negedge i_clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        case (idx)
            erct_pkg::REG_INV_XX:   m_xx  = val;
            erct_pkg::REG_INV_XY:   m_xy  = val;
            erct_pkg::REG_INV_XT:   m_xt  = val;
            erct_pkg::REG_INV_YX:   m_yx  = val;
            erct_pkg::REG_INV_YY:   m_yy  = val;
            erct_pkg::REG_INV_YT:   m_yt  = val;
            erct_pkg::REG_RADIUS_X: rad_x = val[RW-1:0];
            erct_pkg::REG_RADIUS_Y: rad_y = val[RW-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    // wait for the pipeline to drain
    task automatic drain();
        while (pix_q.size() > 0 || pix.valid || cov_q.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_matrix(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                              logic [31:0] d, logic [31:0] e, logic [31:0] f,
                              logic [31:0] rx, logic [31:0] ry);
        write_reg(erct_pkg::REG_INV_XX, a);
        write_reg(erct_pkg::REG_INV_XY, b);
        write_reg(erct_pkg::REG_INV_XT, c);
        write_reg(erct_pkg::REG_INV_YX, d);
        write_reg(erct_pkg::REG_INV_YY, e);
        write_reg(erct_pkg::REG_INV_YT, f);
        write_reg(erct_pkg::REG_RADIUS_X, rx);
        write_reg(erct_pkg::REG_RADIUS_Y, ry);
    endtask

    function automatic t_pixel rand_pixel(int span);
        t_pixel p;
        p.px = CW'($signed($urandom_range(2 * span)) - span);
        p.py = CW'($signed($urandom_range(2 * span)) - span);
        p.lw = ($urandom_range(3) == 0) ? RW'($urandom) : RW'($urandom_range(span << 17));
        p.fill = 1'($urandom_range(1));
        return p;
    endfunction

    // one phase: random words under the given idle and stall pressure
    task automatic run_phase(int n, int idle, int stall, int span);
        send_idle  = idle;
        recv_stall = stall;
        for (int i = 0; i < n; i++) queue_pixel(rand_pixel(span));
        drain();
    endtask

    initial begin
        int sp;
        i_rst_n        = 1'b0;
        pix.valid      = 1'b0;
        pix.pixel_x    = '0;
        pix.pixel_y    = '0;
        pix.line_width = '0;
        pix.fill_mode  = 1'b0;
        cfg.valid      = 1'b0;
        cfg.index      = erct_pkg::REG_INV_XX;
        cfg.data       = '0;
        cov.ready      = 1'b1;
        m_xx = 32'sd65536; m_xy = 0; m_xt = 0;
        m_yx = 0; m_yy = 32'sd65536; m_yt = 0;
        rad_x = '0; rad_y = '0;
        n_err = 0; n_sent = 0; n_seen = 0; n_covered = 0;
        send_idle = 0; recv_stall = 0; hold_pix = 1'b0; pix_acc = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero radius with reset matrix, then field extremes
        queue_pixel({12'sh800, 12'sh7ff, 28'hfffffff, 1'b1});
        queue_pixel({12'sd0, 12'sd0, 28'd0, 1'b0});
        drain();
        set_matrix(32'sd65536, 0, 0, 0, 32'sd65536, 0, 28'd10 << 16, 28'd6 << 16);
        // on the outer boundary, inner boundary, centre, far outside, thick stroke
        queue_pixel({12'sd20, 12'sd6, 28'd0, 1'b1});
        queue_pixel({12'sd20, 12'sd6, 28'd0, 1'b0});
        queue_pixel({12'sd10, 12'sd6, 28'd0, 1'b0});
        queue_pixel({12'sd10, 12'sd6, 28'd0, 1'b1});
        queue_pixel({12'sd10, 12'sd6, 28'd2 << 16, 1'b0});
        queue_pixel({12'sd10, 12'sd6, 28'd12 << 16, 1'b0});
        queue_pixel({12'sd22, 12'sd6, 28'd4 << 16, 1'b0});
        queue_pixel({12'sd21, 12'sd6, 28'd4 << 16, 1'b0});
        queue_pixel({12'sd23, 12'sd6, 28'd4 << 16, 1'b1});
        queue_pixel({12'sd0, 12'sd0, 28'd0, 1'b0});
        queue_pixel({12'sh800, 12'sh800, 28'hfffffff, 1'b0});
        queue_pixel({12'sh7ff, 12'sh7ff, 28'hfffffff, 1'b1});
        queue_pixel({12'sh7ff, 12'sh800, 28'h5555555, 1'b0});
        queue_pixel({12'sh800, 12'sh7ff, 28'haaaaaaa, 1'b1});
        drain();
        // extreme registers, unused index
        set_matrix(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000,
                   32'h7fffffff, 32'h80000000, 32'hfffffff, 32'hfffffff);
        write_reg(erct_pkg::t_reg_idx'(4'd15), 32'hdeadbeef);
        queue_pixel({12'sh7ff, 12'sh800, 28'hfffffff, 1'b0});
        queue_pixel({12'sh800, 12'sh7ff, 28'd0, 1'b0});
        queue_pixel({12'sd0, 12'sd0, 28'd0, 1'b1});
        drain();

        // random phases: ellipse near the origin of screen, varied pressure
        for (int ph = 0; ph < 8; ph++) begin
            sp = (ph % 2) ? 2047 : 64;
            set_matrix(32'($signed($urandom_range(131072)) - 65536),
                       32'($signed($urandom_range(65536)) - 32768),
                       32'($urandom_range(40 << 16)),
                       32'($signed($urandom_range(65536)) - 32768),
                       32'($signed($urandom_range(131072)) - 65536),
                       32'($urandom_range(40 << 16)),
                       (ph == 7) ? 32'd1 : 32'($urandom_range(1, 30 << 16)),
                       (ph == 6) ? 32'hfffffff : 32'($urandom_range(1, 30 << 16)));
            case (ph % 4)
                0: run_phase(NRAND / 8, 0, 0, sp);
                1: run_phase(NRAND / 8, 48, 0, sp);
                2: run_phase(NRAND / 8, 0, 48, sp);
                default: run_phase(NRAND / 8, 26, 26, sp);
            endcase
        end
        // fully random words under fully random registers
        set_matrix($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
        run_phase(100, 26, 26, 2047);

        $display("checked %0d pixel words over twelve register settings, %0d covered",
                 n_seen, n_covered);
        if (n_err == 0 && cov_q.size() == 0) begin
            $display("ellipse_ring_coverage_test test passed");
        end else begin
            $display("ellipse_ring_coverage_test test failed");
        end
        $finish;
    end

    // timeout
    initial begin
        #5ms;
        $display("ellipse_ring_coverage_test test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/erct_pkg.sv
hdl/erct_if.sv
hdl/erct_xform.sv
hdl/erct_ellip.sv
hdl/ellipse_ring_coverage_test.sv
test/tb.sv
